### sv/prt_pkg.sv
// Package: shared types, constants and tables of the phasor resonator tracker.
`timescale 1ns / 1ps
package prt_pkg;

  localparam int TableAddrBits = 10;
  localparam int MaxFrame      = 4096;
  localparam int CordicSteps   = 24;
  localparam int DivSteps      = 32;
  localparam int IterW         = 5;
  localparam int FcW           = $clog2(MaxFrame + 1);
  localparam int CfgIdxW       = 2;
  localparam int CfgDataW      = 32;
  localparam int CordW         = 35;

  localparam logic [29:0] KinvQ30 = 30'd652032874;

  localparam logic [CfgIdxW-1:0] REG_INC       = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_ALPHA     = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_TRACK_EN  = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_THRESHOLD = 2'd3;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               frame_last;
  } in_t;

  typedef struct packed {
    logic [62:0]        power;
    logic [31:0]        amplitude;
    logic [31:0]        tracked_increment;
    logic signed [31:0] phase_angle;
    logic               above_threshold;
  } out_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ROT_INIT,
    OP_CORDIC,
    OP_TAB,
    OP_TGT,
    OP_SM_MUL0,
    OP_SM_MUL1,
    OP_SM_WR,
    OP_ADV,
    OP_VEC_INIT,
    OP_MAG,
    OP_DIV_INIT,
    OP_DIV,
    OP_FIN
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [IterW-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic track_go;
    logic out_busy;
  } sts_t;

  function automatic logic [31:0] atan_turns(input logic [IterW-1:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

### sv/prt_ctrl.sv
// Sequencer for per-item smoothing and frame-end measurement.
`timescale 1ns / 1ps
module prt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  prt_pkg::sts_t sts_i,
  output prt_pkg::cmd_t cmd_o
);
  import prt_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ROT_INIT = 4'd1;
  localparam logic [3:0] S_ROT      = 4'd2;
  localparam logic [3:0] S_TAB      = 4'd3;
  localparam logic [3:0] S_TGT      = 4'd4;
  localparam logic [3:0] S_SM0      = 4'd5;
  localparam logic [3:0] S_SM1      = 4'd6;
  localparam logic [3:0] S_SM2      = 4'd7;
  localparam logic [3:0] S_ADV      = 4'd8;
  localparam logic [3:0] S_VEC_INIT = 4'd9;
  localparam logic [3:0] S_VEC      = 4'd10;
  localparam logic [3:0] S_MAG      = 4'd11;
  localparam logic [3:0] S_DIV_INIT = 4'd12;
  localparam logic [3:0] S_DIV      = 4'd13;
  localparam logic [3:0] S_FIN      = 4'd14;

  localparam logic [IterW-1:0] CordLast = IterW'(CordicSteps - 1);
  localparam logic [IterW-1:0] DivLast  = IterW'(DivSteps - 1);
  localparam logic [IterW-1:0] SmLast   = IterW'(3);
  localparam logic [IterW-1:0] MagLast  = IterW'(5);

  logic [3:0]       state_q, state_d;
  logic [IterW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o.op   = OP_NONE;
    cmd_o.step = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.op   = OP_LOAD;
        if (in_valid_i) state_d = S_ROT_INIT;
      end
      S_ROT_INIT: begin
        cmd_o.op = OP_ROT_INIT;
        cnt_d    = '0;
        state_d  = S_ROT;
      end
      S_ROT: begin
        cmd_o.op = OP_CORDIC;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CordLast) state_d = S_TAB;
      end
      S_TAB: begin
        cmd_o.op = OP_TAB;
        state_d  = S_TGT;
      end
      S_TGT: begin
        cmd_o.op = OP_TGT;
        cnt_d    = '0;
        state_d  = S_SM0;
      end
      S_SM0: begin
        cmd_o.op = OP_SM_MUL0;
        state_d  = S_SM1;
      end
      S_SM1: begin
        cmd_o.op = OP_SM_MUL1;
        state_d  = S_SM2;
      end
      S_SM2: begin
        cmd_o.op = OP_SM_WR;
        cnt_d    = cnt_q + 1'b1;
        state_d  = (cnt_q == SmLast) ? S_ADV : S_SM0;
      end
      S_ADV: begin
        cmd_o.op = OP_ADV;
        state_d  = sts_i.last ? S_VEC_INIT : S_IDLE;
      end
      S_VEC_INIT: begin
        cmd_o.op = OP_VEC_INIT;
        cnt_d    = '0;
        state_d  = S_VEC;
      end
      S_VEC: begin
        cmd_o.op = OP_CORDIC;
        if (cnt_q == CordLast) begin
          cnt_d   = '0;
          state_d = S_MAG;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_MAG: begin
        cmd_o.op = OP_MAG;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == MagLast) state_d = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cnt_d = '0;
        if (sts_i.track_go) begin
          cmd_o.op = OP_DIV_INIT;
          state_d  = S_DIV;
        end else begin
          state_d = S_FIN;
        end
      end
      S_DIV: begin
        cmd_o.op = OP_DIV;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == DivLast) state_d = S_FIN;
      end
      S_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.op = OP_FIN;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

### sv/prt_dp.sv
// Datapath: oscillator, smoothers, shared CORDIC, multipliers, divider, result register.
`timescale 1ns / 1ps
module prt_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  prt_pkg::cmd_t                 cmd_i,
  output prt_pkg::sts_t                 sts_o,
  input  logic                          in_valid_i,
  input  prt_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output prt_pkg::out_t                 out_data_o,
  input  logic                          cfg_we_i,
  input  logic [prt_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [prt_pkg::CfgDataW-1:0]  cfg_data_i
);
  import prt_pkg::*;

  // configuration
  logic [31:0] inc_q, thr_q;
  logic [16:0] alpha_q;
  logic        en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_q   <= '0;
      alpha_q <= 17'd655;
      en_q    <= 1'b0;
      thr_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_INC:       inc_q   <= cfg_data_i;
        REG_ALPHA:     alpha_q <= cfg_data_i[16:0];
        REG_TRACK_EN:  en_q    <= cfg_data_i[0];
        REG_THRESHOLD: thr_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [16:0] a_eff;
  assign a_eff = (alpha_q > 17'd65536) ? 17'd65536 : alpha_q;

  // state
  logic [31:0]        osc_q, prev_q;
  logic [FcW-1:0]     fc_q;
  logic signed [31:0] c1_q, s1_q, c2_q, s2_q;
  logic signed [15:0] smp_q;
  logic               last_q;

  // CORDIC
  logic signed [CordW-1:0] cx_q, cy_q;
  logic [31:0]             cz_q;
  logic                    flip_q, zero_q, rot_q;
  logic signed [15:0]      tc_q, ts_q;
  logic signed [32:0]      tgt_c_q, tgt_s_q;

  // smoothing multiplier
  logic signed [51:0] prod_q;
  logic signed [52:0] acc_q;
  logic signed [17:0] m1_a;
  logic signed [33:0] m1_b;
  logic signed [51:0] m1_p;
  logic signed [31:0] sm_old;
  logic signed [32:0] sm_tgt;

  // wide multiplier
  logic signed [32:0] m2_a, m2_b;
  logic signed [65:0] m2_p;
  logic [63:0]        p2_q;
  logic [64:0]        pw_q;
  logic [65:0]        mg_q;
  logic [33:0]        xm_q;
  logic [31:0]        mag_q;
  logic [62:0]        pow_q;

  // divider
  logic [31:0]    quo_q;
  logic [FcW:0]   rem_q;
  logic [FcW-1:0] div_n_q;
  logic           sub_q, above_q;

  out_t out_q;
  logic out_v_q;

  logic signed [CordW-1:0] dx, dy;
  logic [31:0]             at;
  logic                    pos;
  logic signed [CordW-1:0] fx, fy;
  logic [31:0]             ang, diff, rot_ang;
  logic signed [36:0]      sm_sh;
  logic [FcW:0]            rem_sh, rem_tr;

  function automatic logic signed [15:0] q15(input logic signed [CordW-1:0] v);
    logic signed [CordW:0] t;
    t = ($signed({v[CordW-1], v}) + (CordW+1)'(16384)) >>> 15;
    if (t > (CordW+1)'(32767)) return 16'sh7FFF;
    if (t < -(CordW+1)'(32768)) return 16'sh8000;
    return t[15:0];
  endfunction

  always_comb begin
    dx  = cy_q >>> cmd_i.step;
    dy  = cx_q >>> cmd_i.step;
    at  = atan_turns(cmd_i.step);
    // rotation drives z to zero, vectoring drives y to zero
    pos = rot_q ? !cz_q[31] : !(!cy_q[CordW-1] && (cy_q != '0));
    fx  = flip_q ? -cx_q : cx_q;
    fy  = flip_q ? -cy_q : cy_q;
    rot_ang = {osc_q[31 -: TableAddrBits], {(32-TableAddrBits){1'b0}}};
    ang  = zero_q ? 32'd0 : cz_q;
    diff = ang - prev_q;

    unique case (cmd_i.step[1:0])
      2'd0: begin sm_old = c1_q; sm_tgt = tgt_c_q; end
      2'd1: begin sm_old = s1_q; sm_tgt = tgt_s_q; end
      2'd2: begin sm_old = c2_q; sm_tgt = {c1_q[31], c1_q}; end
      default: begin sm_old = s2_q; sm_tgt = {s1_q[31], s1_q}; end
    endcase
    if (cmd_i.op == OP_SM_MUL0) begin
      m1_a = $signed({1'b0, 17'(17'd65536 - a_eff)});
      m1_b = 34'(sm_old);
    end else begin
      m1_a = $signed({1'b0, a_eff});
      m1_b = 34'(sm_tgt);
    end
    m1_p  = m1_a * m1_b;
    sm_sh = 37'((acc_q + 53'sd32768) >>> 16);

    unique case (cmd_i.step[2:0])
      3'd0: begin m2_a = 33'(c2_q); m2_b = 33'(c2_q); end
      3'd1: begin m2_a = 33'(s2_q); m2_b = 33'(s2_q); end
      3'd2: begin m2_a = $signed({16'd0, xm_q[16:0]}); m2_b = $signed({3'd0, KinvQ30}); end
      default: begin
        m2_a = $signed({16'd0, xm_q[33:17]});
        m2_b = $signed({3'd0, KinvQ30});
      end
    endcase
    m2_p = m2_a * m2_b;

    rem_sh = {rem_q[FcW-1:0], quo_q[31]};
    rem_tr = rem_sh - {1'b0, div_n_q};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD && in_valid_i) begin
      smp_q  <= in_data_i.sample;
      last_q <= in_data_i.frame_last;
    end
    unique case (cmd_i.op)
      OP_ROT_INIT: begin
        cx_q   <= CordW'($signed({1'b0, KinvQ30}));
        cy_q   <= '0;
        flip_q <= rot_ang[31] ^ rot_ang[30];
        cz_q   <= (rot_ang[31] ^ rot_ang[30]) ? {~rot_ang[31], rot_ang[30:0]} : rot_ang;
        rot_q  <= 1'b1;
      end
      OP_CORDIC: begin
        if (pos) begin
          cx_q <= cx_q - dx; cy_q <= cy_q + dy; cz_q <= cz_q - at;
        end else begin
          cx_q <= cx_q + dx; cy_q <= cy_q - dy; cz_q <= cz_q + at;
        end
      end
      OP_TAB: begin
        tc_q <= q15(fx);
        ts_q <= q15(fy);
      end
      OP_TGT: begin
        tgt_c_q <= 33'(smp_q * tc_q) <<< 1;
        tgt_s_q <= 33'(smp_q * ts_q) <<< 1;
      end
      OP_SM_MUL0: prod_q <= m1_p;
      OP_SM_MUL1: acc_q  <= 53'(prod_q) + 53'(m1_p);
      OP_VEC_INIT: begin
        rot_q  <= 1'b0;
        flip_q <= 1'b0;
        zero_q <= (c2_q == '0) && (s2_q == '0);
        if (c2_q[31]) begin
          cx_q <= -CordW'(c2_q); cy_q <= -CordW'(s2_q); cz_q <= 32'h80000000;
        end else begin
          cx_q <= CordW'(c2_q); cy_q <= CordW'(s2_q); cz_q <= '0;
        end
      end
      OP_MAG: begin
        unique case (cmd_i.step[2:0])
          3'd0: begin
            p2_q <= m2_p[63:0];
            xm_q <= cx_q[CordW-1] ? '0 : cx_q[33:0];
          end
          3'd1: begin pw_q <= {1'b0, p2_q}; p2_q <= m2_p[63:0]; end
          3'd2: begin pw_q <= pw_q + {1'b0, p2_q}; p2_q <= m2_p[63:0]; end
          3'd3: begin mg_q <= {2'b0, p2_q}; p2_q <= m2_p[63:0]; end
          3'd4: mg_q <= mg_q + ({2'b0, p2_q} << 17) + 66'(1 << 29);
          default: begin
            mag_q <= zero_q ? 32'd0 : ((mg_q[65:62] != '0) ? 32'hFFFFFFFF : mg_q[61:30]);
            pow_q <= (pw_q[64:63] != '0) ? {63{1'b1}} : pw_q[62:0];
          end
        endcase
      end
      OP_DIV_INIT: begin
        sub_q   <= (diff <= 32'h80000000);
        quo_q   <= (diff <= 32'h80000000) ? diff : -diff;
        rem_q   <= '0;
        div_n_q <= (fc_q == '0) ? FcW'(1) : fc_q;
      end
      OP_DIV: begin
        if (!rem_tr[FcW]) begin
          rem_q <= rem_tr;
          quo_q <= {quo_q[30:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[30:0], 1'b0};
        end
      end
      default: ;
    endcase
    if (cmd_i.op == OP_FIN) begin
      out_q.power             <= pow_q;
      out_q.amplitude         <= mag_q;
      out_q.phase_angle       <= ang;
      out_q.above_threshold   <= above_q;
      out_q.tracked_increment <= !above_q ? inc_q : (sub_q ? inc_q - quo_q : inc_q + quo_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      osc_q   <= '0;
      prev_q  <= '0;
      fc_q    <= '0;
      c1_q    <= '0;
      s1_q    <= '0;
      c2_q    <= '0;
      s2_q    <= '0;
      above_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_FIN) begin
        out_v_q <= 1'b1;
      end else if (out_v_q && out_ready_i) begin
        out_v_q <= 1'b0;
      end
      unique case (cmd_i.op)
        OP_SM_WR: begin
          logic signed [31:0] sv;
          sv = (sm_sh > 37'sh7FFFFFFF) ? 32'sh7FFFFFFF :
               (sm_sh < -37'sh80000000) ? 32'sh80000000 : sm_sh[31:0];
          unique case (cmd_i.step[1:0])
            2'd0: c1_q <= sv;
            2'd1: s1_q <= sv;
            2'd2: c2_q <= sv;
            default: s2_q <= sv;
          endcase
        end
        OP_ADV: begin
          osc_q <= osc_q + inc_q;
          if (fc_q < FcW'(MaxFrame)) fc_q <= fc_q + 1'b1;
        end
        OP_VEC_INIT: above_q <= 1'b0;
        OP_DIV_INIT: begin
          above_q <= 1'b1;
          prev_q  <= ang;
        end
        OP_FIN: fc_q <= '0;
        default: ;
      endcase
    end
  end

  assign sts_o.last     = last_q;
  assign sts_o.track_go = en_q && (mag_q > thr_q);
  assign sts_o.out_busy = out_v_q && !out_ready_i;
  assign out_valid_o    = out_v_q;
  assign out_data_o     = out_q;

endmodule

### sv/phasor_resonator_tracker_unit.sv
// Top level: phasor resonator with frequency tracking.
//
//   channel   dir  handshake                  payload
//   in        in   in_valid_i / in_ready_o    in_data_i  (sample, frame_last)
//   out       out  out_valid_o / out_ready_i  out_data_o (power .. above_threshold)
//   cfg       in   cfg_we_i                   cfg_index_i, cfg_data_i
//
// An item without frame end runs CordicSteps rotation steps of the shared CORDIC
// for the oscillator value, three steps per smoother (two multiplies and a write),
// and the rotation setup, table, target and advance steps. A frame-end item adds the
// vectoring setup, CordicSteps vectoring steps, the magnitude, divider setup and
// finish steps, plus the divider steps when tracking updates. Reset clears the
// configuration, oscillator, smoothers, frame count and output valid at once, but
// not the working or result registers. The result waits in an output register; the
// next item is taken meanwhile, and a second result stalls until the first leaves.
`timescale 1ns / 1ps
module phasor_resonator_tracker_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  prt_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output prt_pkg::out_t                 out_data_o,
  input  logic                          cfg_we_i,
  input  logic [prt_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [prt_pkg::CfgDataW-1:0]  cfg_data_i
);
  import prt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  prt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  prt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while previous item in work");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.op) == OP_FIN)
    else $error("result shown without frame-end finish");

  a_fin_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == OP_FIN |-> !(out_valid_o && !out_ready_i))
    else $error("result register overwritten");

endmodule

### sim/tb_top.sv
// Testbench for the phasor resonator tracker: scoreboard with bit-exact predictor.
`timescale 1ns / 1ps
module tb_top;
  import prt_pkg::*;

  localparam int WatchLimit = 3000;
  localparam int SettleCycles = 160;

  class resonator_scoreboard;
    int      cos_t[1024];
    int      sin_t[1024];
    bit [31:0] atan_lut[24];
    bit [31:0] inc, thr;
    bit [16:0] alpha;
    bit      trk_en;
    bit [31:0] osc;
    int      c1, s1, c2, s2;
    bit [31:0] prev_ang;
    int      fcount;
    out_t    pending_q[$];
    int      errors;

    function new();
      atan_lut = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
                   32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
                   32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
                   32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
                   32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
      inc = 0; alpha = 655; trk_en = 0; thr = 0;
      osc = 0; c1 = 0; s1 = 0; c2 = 0; s2 = 0; prev_ang = 0; fcount = 0;
      errors = 0;
      build_osc_table();
    endfunction

    function int to_q15(longint v);
      longint r;
      r = (v + 16384) >>> 15;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return int'(r);
    endfunction

    // rotation CORDIC from K^-1, quadrants 1 and 2 folded by a half turn
    function void build_osc_table();
      bit [31:0] ang, zu;
      bit flip;
      longint x, y, z, dx, dy;
      for (int k = 0; k < 1024; k++) begin
        ang = 32'(k) << 22;
        flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
        zu = flip ? ang - 32'h80000000 : ang;
        z = longint'($signed(zu));
        x = 652032874;
        y = 0;
        for (int i = 0; i < 24; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(atan_lut[i]);
          end else begin
            x += dx; y -= dy; z += longint'(atan_lut[i]);
          end
        end
        if (flip) begin
          x = -x; y = -y;
        end
        cos_t[k] = to_q15(x);
        sin_t[k] = to_q15(y);
      end
    endfunction

    function int smooth_step(int old, longint target, longint a);
      longint acc;
      acc = ((65536 - a) * longint'(old) + a * target + 32768) >>> 16;
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      if (acc < -64'sd2147483648) acc = -64'sd2147483648;
      return int'(acc);
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, bit [31:0] val);
      case (idx)
        REG_INC:       inc = val;
        REG_ALPHA:     alpha = val[16:0];
        REG_TRACK_EN:  trk_en = val[0];
        REG_THRESHOLD: thr = val;
        default: ;
      endcase
    endfunction

    function void note_sample(in_t d);
      longint s, a, x, y, dx, dy, n;
      longint unsigned ac, as, pw, m;
      bit [31:0] z, diff, mag, tracked;
      bit above;
      int idx;
      out_t r;
      s = longint'($signed(d.sample));
      a = (alpha > 17'd65536) ? 65536 : longint'(alpha);
      idx = int'(osc >> 22);
      c1 = smooth_step(c1, 2 * s * cos_t[idx], a);
      s1 = smooth_step(s1, 2 * s * sin_t[idx], a);
      c2 = smooth_step(c2, c1, a);
      s2 = smooth_step(s2, s1, a);
      osc += inc;
      if (fcount < MaxFrame) fcount++;
      if (!d.frame_last) return;
      ac = (c2 < 0) ? longint'(-longint'(c2)) : longint'(c2);
      as = (s2 < 0) ? longint'(-longint'(s2)) : longint'(s2);
      pw = ac * ac + as * as;
      if (pw > 64'h7FFFFFFFFFFFFFFF) pw = 64'h7FFFFFFFFFFFFFFF;
      // vectoring CORDIC on the second-stage phasor
      x = c2; y = s2; z = 0;
      if (x == 0 && y == 0) begin
        mag = 0;
      end else begin
        if (x < 0) begin
          x = -x; y = -y; z = 32'h80000000;
        end
        for (int i = 0; i < 24; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (y > 0) begin
            x += dx; y -= dy; z += atan_lut[i];
          end else begin
            x -= dx; y += dy; z -= atan_lut[i];
          end
        end
        if (x < 0) x = 0;
        m = (longint'(x) * 64'd652032874 + (64'd1 << 29)) >> 30;
        mag = (m > 64'hFFFFFFFF) ? 32'hFFFFFFFF : m[31:0];
      end
      tracked = inc;
      above = 0;
      if (trk_en && mag > thr) begin
        diff = z - prev_ang;
        n = (fcount != 0) ? fcount : 1;
        if (diff <= 32'h80000000)
          tracked = inc - 32'(longint'(diff) / n);
        else
          tracked = inc + 32'((64'd4294967296 - longint'(diff)) / n);
        prev_ang = z;
        above = 1;
      end
      fcount = 0;
      r.power = pw[62:0];
      r.amplitude = mag;
      r.tracked_increment = tracked;
      r.phase_angle = z;
      r.above_threshold = above;
      pending_q.push_back(r);
    endfunction

    function void check_result(out_t got);
      out_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: result with none expected, got %h", $realtime, got);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (got.power !== e.power) begin
        $display("%0t: power exp %h got %h", $realtime, e.power, got.power);
        errors++;
      end
      if (got.amplitude !== e.amplitude) begin
        $display("%0t: amplitude exp %h got %h", $realtime, e.amplitude, got.amplitude);
        errors++;
      end
      if (got.tracked_increment !== e.tracked_increment) begin
        $display("%0t: tracked_increment exp %h got %h", $realtime,
                 e.tracked_increment, got.tracked_increment);
        errors++;
      end
      if (got.phase_angle !== e.phase_angle) begin
        $display("%0t: phase_angle exp %h got %h", $realtime, e.phase_angle, got.phase_angle);
        errors++;
      end
      if (got.above_threshold !== e.above_threshold) begin
        $display("%0t: above_threshold exp %b got %b", $realtime,
                 e.above_threshold, got.above_threshold);
        errors++;
      end
    endfunction

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid, in_ready, out_valid, out_ready;
  in_t  in_data;
  out_t out_data;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  resonator_scoreboard sb;
  bit no_idle;
  bit hold_req;
  int quiet_cycles;
  bit [31:0] tone_phase;

  phasor_resonator_tracker_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  function int draw_gap();
    if (no_idle) return 0;
    return $urandom_range(0, 6);
  endfunction

  task send_item(input logic signed [15:0] smp, input logic last);
    int gap;
    in_t d;
    gap = draw_gap();
    d.sample = smp;
    d.frame_last = last;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1;
    in_data <= d;
    do @(posedge clk_i); while (!in_ready);
    sb.note_sample(d);
  endtask

  task write_reg(input logic [CfgIdxW-1:0] idx, input bit [31:0] val);
    @(negedge clk_i);
    in_valid <= 0;
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we <= 0;
  endtask

  // sender pauses until all results are back, then lets the block settle
  task drain();
    @(negedge clk_i);
    in_valid <= 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function logic signed [15:0] next_sample(int amp_shift);
    logic signed [15:0] v;
    if ($urandom_range(0, 9) < 7) begin
      v = 16'(sb.cos_t[tone_phase >> 22] >>> amp_shift);
      tone_phase += sb.inc + $urandom_range(0, 1 << 20) - (1 << 19);
    end else begin
      v = 16'($urandom);
    end
    return v;
  endfunction

  task random_phase(input int nitems);
    int sent, flen, shift;
    sent = 0;
    while (sent < nitems) begin
      flen = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
      shift = $urandom_range(0, 4);
      for (int k = 0; k < flen; k++) send_item(next_sample(shift), k == flen - 1);
      sent += flen;
    end
  endtask

  function bit [31:0] pick32(input bit [31:0] lo_max);
    case ($urandom_range(0, 3))
      0: return 32'h0;
      1: return 32'hFFFFFFFF;
      2: return $urandom;
      default: return $urandom_range(0, lo_max);
    endcase
  endfunction

  // receiver: random stalls, one long hold-off on request
  initial begin
    int gap;
    out_ready = 0;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap();
      if (hold_req) begin
        gap = 400;
        hold_req = 0;
      end
      @(negedge clk_i);
      if (gap != 0) begin
        out_ready <= 0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready <= 1;
      do @(posedge clk_i); while (!out_valid);
      sb.check_result(out_data);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    sb = new();
    in_valid = 0;
    in_data = '0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    no_idle = 0;
    hold_req = 0;
    quiet_cycles = 0;
    tone_phase = 0;
    rst_ni = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed: zero phasor, extremes of the sample, half-turn angle, tracking
    send_item(16'sd0, 1'b0);
    send_item(16'sd0, 1'b1);
    drain();
    write_reg(REG_ALPHA, 32'd65536);
    write_reg(REG_INC, 32'd0);
    send_item(-16'sd32768, 1'b1);
    send_item(16'sd32767, 1'b1);
    drain();
    write_reg(REG_ALPHA, 32'h1FFFF);
    write_reg(REG_TRACK_EN, 32'd1);
    write_reg(REG_THRESHOLD, 32'd0);
    write_reg(REG_INC, 32'h40000000);
    for (int k = 0; k < 8; k++) send_item(16'sd32767, k[0]);
    send_item(-16'sd32768, 1'b0);
    send_item(-16'sd32768, 1'b1);
    drain();
    write_reg(REG_THRESHOLD, 32'hFFFFFFFF);
    write_reg(REG_INC, 32'hFFFFFFFF);
    send_item(16'sd12345, 1'b0);
    send_item(-16'sd1, 1'b1);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      no_idle = (ph % 3 == 0);
      write_reg(REG_INC, pick32(32'h08000000));
      case ($urandom_range(0, 4))
        0: write_reg(REG_ALPHA, 32'd0);
        1: write_reg(REG_ALPHA, 32'd65536);
        2: write_reg(REG_ALPHA, $urandom_range(65537, 131071));
        3: write_reg(REG_ALPHA, $urandom_range(256, 8192));
        default: write_reg(REG_ALPHA, $urandom_range(0, 65536));
      endcase
      write_reg(REG_TRACK_EN, (ph == 1) ? 32'd0 : 32'($urandom_range(0, 3) != 0));
      write_reg(REG_THRESHOLD, pick32(32'h01000000));
      if (ph == 4) begin
        // back-to-back results while the receiver holds off
        hold_req = 1;
        for (int k = 0; k < 30; k++) send_item(16'($urandom), 1'b1);
      end
      random_phase(150);
      drain();
    end

    repeat (SettleCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
